/* sv/averaged_frequency_window_detector_defines.svh */
// ----------------------------------------------------------------------------
// averaged frequency window detector assertion macros
// shared property wrappers on clk_i with rst_ni as the disable condition
// ----------------------------------------------------------------------------
`ifndef AVERAGED_FREQUENCY_WINDOW_DETECTOR_DEFINES_SVH
`define AVERAGED_FREQUENCY_WINDOW_DETECTOR_DEFINES_SVH

// same-cycle implication
`define AFWD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFWD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/afwd_pkg.sv */
// ----------------------------------------------------------------------------
// afwd_pkg
// widths, register codes and reset constants of the frequency window detector
// ----------------------------------------------------------------------------
package afwd_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ACC_W      = 40;
  localparam int unsigned FREQ_W     = 20;
  localparam int unsigned SAMPLES_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [FREQ_W-1:0]    FREQ_CEILING = 20'd1000000;
  localparam logic [SAMPLES_W-1:0] RST_SAMPLES  = 8'd25;
  localparam logic [FREQ_W-1:0]    RST_LOW_HZ   = 20'd2970;
  localparam logic [FREQ_W-1:0]    RST_HIGH_HZ  = 20'd3050;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLES = 2'd0,
    CFG_LOW     = 2'd1,
    CFG_HIGH    = 2'd2
  } cfg_reg_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_stat_t;

endpackage

/* sv/afwd_div.sv */
// ----------------------------------------------------------------------------
// afwd_div
// restoring divider, one quotient bit per cycle through one 41-bit subtractor
// ----------------------------------------------------------------------------
`include "averaged_frequency_window_detector_defines.svh"

module afwd_div #(
  parameter int unsigned NUM_W = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NUM_W-1:0]            dividend_i,
  input  logic [afwd_pkg::ACC_W-1:0]  divisor_i,
  output logic [NUM_W-1:0]            quotient_o,
  output afwd_pkg::div_stat_t         stat_o
);
  import afwd_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [ACC_W-1:0] rem_q, rem_d;
  logic [ACC_W-1:0] dvs_q, dvs_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [ACC_W:0]   trial;
  logic [ACC_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the difference fits back
      rem_d = ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign stat_o.busy   = busy_q;
  assign stat_o.done   = done_q;
  assign stat_o.rem_nz = |rem_q;

  `AFWD_ASSERT_NXT(a_start_loads, start_i && !busy_q, busy_q, "divider did not start")
  `AFWD_ASSERT_IMP(a_start_idle, start_i, !busy_q, "divider started while busy")
  `AFWD_ASSERT_IMP(a_rem_below, busy_q, rem_q < dvs_q, "partial remainder not below divisor")

endmodule

/* sv/averaged_frequency_window_detector.sv */
// ----------------------------------------------------------------------------
// averaged frequency window detector
// Each input word is a falling-edge timestamp in ticks; the block sums edge
// periods (modulo 2^32 each) over samples_per_average edges, latches the sum
// and returns one result word per edge: floor(TICKS_PER_SECOND * N / sum)
// capped at 1000000 (1000000 while the latched sum is zero), a flag when the
// exact frequency lies above high_threshold_hz or below low_threshold_hz,
// and a flag marking the edge that completed a window. An accepted edge
// passes ST_MUL, ST_DIV and ST_OUT to its result, skipping ST_DIV while
// the latched sum is zero; NUM_W = clog2(TICKS_PER_SECOND*255+1)
// is the quotient width the shared one-bit-per-cycle divider walks through.
// The input is not ready while an edge is in work; a finished result waits
// in the output register, so the next edge can be taken meanwhile.
// ----------------------------------------------------------------------------
`include "averaged_frequency_window_detector_defines.svh"

module averaged_frequency_window_detector #(
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [afwd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [afwd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [afwd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [31:0] edge_time_us
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [19:0] frequency_hz, [20] out_of_window, [21] new_average, [23:22] zero
  output logic [afwd_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import afwd_pkg::*;

  localparam longint unsigned NumMax = 64'(TICKS_PER_SECOND) * 64'd255;
  localparam int unsigned     NUM_W  = $clog2(NumMax + 64'd1);
  localparam int unsigned     CMP_W  = (NUM_W > FREQ_W) ? NUM_W : FREQ_W;
  localparam logic [NUM_W-1:0] TpsVal = NUM_W'(TICKS_PER_SECOND);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } afwd_state_e;

  afwd_state_e          st_q, st_d;

  logic [SAMPLES_W-1:0] samples_q;
  logic [FREQ_W-1:0]    low_q;
  logic [FREQ_W-1:0]    high_q;

  logic [TIME_W-1:0]    prev_q, prev_d;
  logic [SAMPLES_W-1:0] count_q, count_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [ACC_W-1:0]     lat_q, lat_d;
  logic [SAMPLES_W-1:0] n_q, n_d;
  logic                 fresh_q, fresh_d;
  logic                 lat_zero_q, lat_zero_d;

  logic                 out_valid_q, out_valid_d;
  logic [FREQ_W-1:0]    out_freq_q, out_freq_d;
  logic                 out_flag_q, out_flag_d;
  logic                 out_new_q, out_new_d;

  logic                 in_fire;
  logic [TIME_W-1:0]    period;
  logic [ACC_W-1:0]     acc_sum;
  logic [SAMPLES_W-1:0] cnt_inc;
  logic [SAMPLES_W-1:0] n_eff;
  logic                 div_start;
  logic [NUM_W-1:0]     dividend;
  logic [NUM_W-1:0]     quotient;
  div_stat_t            div_stat;
  logic [CMP_W-1:0]     q_ext;
  logic [FREQ_W-1:0]    freq_calc;
  logic                 flag_calc;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q <= RST_SAMPLES;
      low_q     <= RST_LOW_HZ;
      high_q    <= RST_HIGH_HZ;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SAMPLES: samples_q <= cfg_data_i[SAMPLES_W-1:0];
        CFG_LOW:     low_q     <= cfg_data_i;
        CFG_HIGH:    high_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // period accumulation at acceptance
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign period  = s_axis_tdata[TIME_W-1:0] - prev_q;
  assign acc_sum = acc_q + ACC_W'(period);
  assign cnt_inc = count_q + 1'b1;
  assign n_eff   = (samples_q == '0) ? SAMPLES_W'(1) : samples_q;

  assign dividend  = TpsVal * NUM_W'(n_q);
  assign div_start = (st_q == ST_MUL) && !lat_zero_q;

  afwd_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (lat_q),
    .quotient_o (quotient),
    .stat_o     (div_stat)
  );

  // num > high*sum iff q > high, or q == high with a remainder left
  assign q_ext = CMP_W'(quotient);
  always_comb begin
    if (lat_zero_q) begin
      freq_calc = FREQ_CEILING;
      flag_calc = 1'b1;
    end else begin
      freq_calc = (q_ext > CMP_W'(FREQ_CEILING)) ? FREQ_CEILING : q_ext[FREQ_W-1:0];
      flag_calc = (q_ext > CMP_W'(high_q)) ||
                  ((q_ext == CMP_W'(high_q)) && div_stat.rem_nz) ||
                  (q_ext < CMP_W'(low_q));
    end
  end

  always_comb begin
    st_d        = st_q;
    prev_d      = prev_q;
    count_d     = count_q;
    acc_d       = acc_q;
    lat_d       = lat_q;
    n_d         = n_q;
    fresh_d     = fresh_q;
    lat_zero_d  = lat_zero_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_freq_d  = out_freq_q;
    out_flag_d  = out_flag_q;
    out_new_d   = out_new_q;
    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          prev_d  = s_axis_tdata[TIME_W-1:0];
          n_d     = n_eff;
          if (cnt_inc >= n_eff) begin
            lat_d      = acc_sum;
            lat_zero_d = (acc_sum == '0);
            acc_d      = '0;
            count_d    = '0;
            fresh_d    = 1'b1;
          end else begin
            acc_d      = acc_sum;
            count_d    = cnt_inc;
            fresh_d    = 1'b0;
          end
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        st_d = lat_zero_q ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_freq_d  = freq_calc;
          out_flag_d  = flag_calc;
          out_new_d   = fresh_q;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      prev_q      <= '0;
      count_q     <= '0;
      acc_q       <= '0;
      lat_q       <= '0;
      lat_zero_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      prev_q      <= prev_d;
      count_q     <= count_d;
      acc_q       <= acc_d;
      lat_q       <= lat_d;
      lat_zero_q  <= lat_zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    fresh_q    <= fresh_d;
    out_freq_q <= out_freq_d;
    out_flag_q <= out_flag_d;
    out_new_q  <= out_new_d;
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_new_q, out_flag_q, out_freq_q};

  `AFWD_ASSERT_NXT(a_busy_after_accept, in_fire, !s_axis_tready, "input ready during work")
  `AFWD_ASSERT_NXT(a_prev_tracks, in_fire, prev_q == $past(s_axis_tdata), "previous edge not kept")
  `AFWD_ASSERT_IMP(a_freq_capped, out_valid_q, out_freq_q <= FREQ_CEILING, "frequency above ceiling")
  `AFWD_ASSERT_IMP(a_zero_sum_no_div, lat_zero_q, !div_start, "divide by zero sum")

endmodule
